[hdl/tfmc_pkg.sv]
package tfmc_pkg;

    // Field widths.
    localparam int unsigned TEMP_W  = 15;
    localparam int unsigned PWR_W   = 11;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned DATA_W  = 16;

    // Full fan power, 100% in sixteenths of a percent.
    localparam logic [PWR_W-1:0] PWR_FULL = 11'd1600;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_TRIP_TEMP        = 3'd0;
    localparam logic [IDX_W-1:0] REG_POWER_INIT       = 3'd1;
    localparam logic [IDX_W-1:0] REG_POWER_STEP       = 3'd2;
    localparam logic [IDX_W-1:0] REG_LASER_POWER      = 3'd3;
    localparam logic [IDX_W-1:0] REG_COOL_HOLD        = 3'd4;
    localparam logic [IDX_W-1:0] REG_TEMP_SOURCE      = 3'd5;
    localparam logic [IDX_W-1:0] REG_LASER_FAN_ENABLE = 3'd6;

    // Temperature source selector codes.
    localparam logic [1:0] SRC_MODULE  = 2'd1;
    localparam logic [1:0] SRC_HIGHEST = 2'd2;

    typedef struct packed {
        logic signed [TEMP_W-1:0] trip_temp;
        logic [PWR_W-1:0]         power_init;
        logic [PWR_W-1:0]         power_step;
        logic [PWR_W-1:0]         laser_power;
        logic [DELAY_W-1:0]       cool_hold;
        logic [1:0]               temp_source;
        logic                     laser_fan_enable;
    } cfg_t;

    typedef struct packed {
        logic                     laser_on;
        logic signed [TEMP_W-1:0] module_temp;
        logic signed [TEMP_W-1:0] highest_temp;
        logic [PWR_W-1:0]         manual_power;
        logic                     aux_request;
        logic [PWR_W-1:0]         aux_power;
    } item_t;

    typedef struct packed {
        logic              drive_write;
        logic              drive_on;
        logic [PWR_W-1:0]  drive_power;
        logic [MODE_W-1:0] fan_state;
    } result_t;

    // Clamp a power value to 100%.
    function automatic logic [PWR_W-1:0] sat_pwr(input logic [PWR_W-1:0] p);
        return (p > PWR_FULL) ? PWR_FULL : p;
    endfunction

endpackage

[hdl/tfmc_cfg.sv]
module tfmc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [tfmc_pkg::IDX_W-1:0]  wr_index,
    input  logic [tfmc_pkg::DATA_W-1:0] wr_data,
    output tfmc_pkg::cfg_t              cfg
);
    import tfmc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a register write; indexes past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_TRIP_TEMP:        cfg_next.trip_temp        = signed'(wr_data[TEMP_W-1:0]);
                REG_POWER_INIT:       cfg_next.power_init       = wr_data[PWR_W-1:0];
                REG_POWER_STEP:       cfg_next.power_step       = wr_data[PWR_W-1:0];
                REG_LASER_POWER:      cfg_next.laser_power      = wr_data[PWR_W-1:0];
                REG_COOL_HOLD:        cfg_next.cool_hold        = wr_data[DELAY_W-1:0];
                REG_TEMP_SOURCE:      cfg_next.temp_source      = wr_data[1:0];
                REG_LASER_FAN_ENABLE: cfg_next.laser_fan_enable = wr_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trip_temp        <= 15'sd560;
            cfg_reg.power_init       <= 11'd800;
            cfg_reg.power_step       <= 11'd160;
            cfg_reg.laser_power      <= 11'd1280;
            cfg_reg.cool_hold        <= 16'd180;
            cfg_reg.temp_source      <= 2'd0;
            cfg_reg.laser_fan_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/tfmc_step.sv]
module tfmc_step (
    input  logic              clk,
    input  logic              rst_n,
    input  tfmc_pkg::cfg_t    cfg,
    input  tfmc_pkg::item_t   item,
    input  logic              fire,
    output tfmc_pkg::result_t result
);
    import tfmc_pkg::*;

    typedef enum logic [MODE_W-1:0] {
        M_IDLE    = 3'd0,
        M_LASER   = 3'd1,
        M_AUX     = 3'd2,
        M_THERMAL = 3'd3,
        M_COOL    = 3'd4
    } mode_t;

    mode_t              mode_reg;
    mode_t              mode_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W:0]   diff;
    logic                     hot;
    logic [TEMP_W-1:0]        excess;
    logic [25:0]              product;
    logic [22:0]              ramp_sum;
    logic [PWR_W-1:0]         thermal;
    logic [PWR_W-1:0]         req_aux;
    logic [PWR_W-1:0]         req;
    logic                     aux_wanted;
    logic [COUNT_W-1:0]       count_inc;

    // Temperature source and the thermal ramp.
    always_comb
    begin
        case (cfg.temp_source)
            SRC_HIGHEST: temp = item.highest_temp;
            SRC_MODULE:  temp = item.module_temp;
            default:     temp = '0;
        endcase
        diff     = {temp[TEMP_W-1], temp} - {cfg.trip_temp[TEMP_W-1], cfg.trip_temp};
        hot      = (temp >= cfg.trip_temp);
        excess   = diff[TEMP_W-1:0];
        product  = 26'(excess) * 26'(cfg.power_step);
        ramp_sum = 23'(product[25:4]) + 23'(cfg.power_init);
        if (!hot)
            thermal = '0;
        else if (ramp_sum > 23'(PWR_FULL))
            thermal = PWR_FULL;
        else
            thermal = ramp_sum[PWR_W-1:0];
    end

    // Accessory request power: the largest of manual, accessory and ramp.
    always_comb
    begin
        aux_wanted = (item.manual_power != '0) || item.aux_request;
        req_aux    = (item.aux_request && (item.aux_power > item.manual_power)) ?
                     item.aux_power : item.manual_power;
        req        = (hot && (thermal > req_aux)) ? thermal : req_aux;
        count_inc  = count_reg + 17'd1;
    end

    // Mode decision for one tick.
    always_comb
    begin
        mode_next          = mode_reg;
        count_next         = count_reg;
        result.drive_write = 1'b0;
        result.drive_on    = 1'b0;
        result.drive_power = '0;
        if (item.laser_on)
        begin
            if (cfg.laser_fan_enable)
            begin
                result.drive_write = 1'b1;
                result.drive_on    = 1'b1;
                result.drive_power = sat_pwr(cfg.laser_power);
                mode_next          = M_LASER;
                count_next         = '0;
            end
        end
        else if (aux_wanted)
        begin
            result.drive_write = 1'b1;
            result.drive_on    = 1'b1;
            result.drive_power = sat_pwr(req);
            mode_next          = M_AUX;
            count_next         = '0;
        end
        else if (hot)
        begin
            result.drive_write = 1'b1;
            result.drive_on    = 1'b1;
            result.drive_power = thermal;
            mode_next          = M_THERMAL;
            count_next         = '0;
        end
        else
        begin
            unique case (mode_reg)
                M_AUX:
                begin
                    result.drive_write = 1'b1;
                    mode_next          = M_IDLE;
                    count_next         = '0;
                end
                M_LASER, M_THERMAL:
                begin
                    mode_next  = M_COOL;
                    count_next = '0;
                end
                M_COOL:
                begin
                    if (count_inc > COUNT_W'(cfg.cool_hold))
                    begin
                        result.drive_write = 1'b1;
                        mode_next          = M_IDLE;
                        count_next         = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                default:
                begin
                    mode_next  = mode_reg;
                    count_next = count_reg;
                end
            endcase
        end
        result.fan_state = mode_next;
    end

    // Mode and cooldown count advance once per tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            count_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule

[hdl/thermal_fan_mode_controller_core.sv]
// Channel   Direction  Handshake           Payload
// in        sink       in_valid/in_stall   laser_on, module_temp, highest_temp,
//                                          manual_power, aux_request, aux_power
// out       source     out_valid/out_stall drive_write, drive_on, drive_power, fan_state
// cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One tick is accepted every cycle while in_stall is low; each accepted beat is held in
// the input register, then passes through the mode logic and ramp multiplier into the
// result register once that register is free.
// Reset clears the configuration to its defaults, the mode to idle and the
// cooldown count to zero. A stalled result holds the result register, and the
// input register still takes one more beat before in_stall rises.
module thermal_fan_mode_controller_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               laser_on,
    input  logic signed [tfmc_pkg::TEMP_W-1:0] module_temp,
    input  logic signed [tfmc_pkg::TEMP_W-1:0] highest_temp,
    input  logic [tfmc_pkg::PWR_W-1:0]         manual_power,
    input  logic                               aux_request,
    input  logic [tfmc_pkg::PWR_W-1:0]         aux_power,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               drive_write,
    output logic                               drive_on,
    output logic [tfmc_pkg::PWR_W-1:0]         drive_power,
    output logic [tfmc_pkg::MODE_W-1:0]        fan_state,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tfmc_pkg::IDX_W-1:0]         cfg_index,
    input  logic [tfmc_pkg::DATA_W-1:0]        cfg_data
);
    import tfmc_pkg::*;

    cfg_t    cfg;
    item_t   item_in;
    item_t   s1_item_reg;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    result_t step_res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    in_take;
    logic    fire;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    tfmc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Gather the input beat.
    always_comb
    begin
        item_in.laser_on     = laser_on;
        item_in.module_temp  = module_temp;
        item_in.highest_temp = highest_temp;
        item_in.manual_power = manual_power;
        item_in.aux_request  = aux_request;
        item_in.aux_power    = aux_power;
    end

    // Pipeline control: the result register frees up when empty or taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign fire     = s1_valid_reg && advance;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    tfmc_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (s1_item_reg),
        .fire   (fire),
        .result (step_res)
    );

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= item_in;
        if (fire)
            out_res_reg <= step_res;
    end

    assign out_valid   = out_valid_reg;
    assign drive_write = out_res_reg.drive_write;
    assign drive_on    = out_res_reg.drive_on;
    assign drive_power = out_res_reg.drive_power;
    assign fan_state   = out_res_reg.fan_state;

`ifndef NO_ASSERTIONS
    // A staged beat that may advance shows up as a result on the next edge.
    a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("staged beat did not reach the result register");

    // Power never exceeds full scale.
    a_power_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_res_reg.drive_power <= PWR_FULL))
        else $error("drive_power above full scale");

    // The switch is only turned on through a command, and power implies on.
    a_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.drive_on || (out_res_reg.drive_power != '0))
            |-> out_res_reg.drive_write && out_res_reg.drive_on)
        else $error("fan power without a switch-on command");

    // The input side only stalls while the result register is held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && s1_valid_reg))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

[test/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tfmc_pkg::*;

    // Fan modes as reported in fan_state.
    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE    = 3'd0,
        MODE_LASER   = 3'd1,
        MODE_AUX     = 3'd2,
        MODE_THERMAL = 3'd3,
        MODE_COOL    = 3'd4
    } fan_mode_e;

    // Source codes and a register index that the package does not name.
    localparam logic [1:0]       SRC_ZERO     = 2'd0;
    localparam logic [1:0]       SRC_RESERVED = 2'd3;
    localparam logic [IDX_W-1:0] REG_UNUSED   = 3'd7;

    localparam int PHASES          = 7;
    localparam int PHASE_TICKS     = 80;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam int TIMEOUT_NS      = 3_000_000;

    // One line of the directed table: either a register write or a tick.
    typedef struct {
        bit                is_write;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] reg_data;
        item_t             tick;
        bit                known;
        result_t           want;
    } step_row_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                     in_valid     = 1'b0;
    logic                     in_stall;
    logic                     laser_on     = 1'b0;
    logic signed [TEMP_W-1:0] module_temp  = '0;
    logic signed [TEMP_W-1:0] highest_temp = '0;
    logic [PWR_W-1:0]         manual_power = '0;
    logic                     aux_request  = 1'b0;
    logic [PWR_W-1:0]         aux_power    = '0;

    logic                     out_valid;
    logic                     out_stall    = 1'b0;
    logic                     drive_write;
    logic                     drive_on;
    logic [PWR_W-1:0]         drive_power;
    logic [MODE_W-1:0]        fan_state;

    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [IDX_W-1:0]         cfg_index    = '0;
    logic [DATA_W-1:0]        cfg_data     = '0;

    // Shadow of the controller: its settings, mode and cooldown counter.
    cfg_t                     fan_cfg;
    fan_mode_e                mode_now;
    logic [COUNT_W-1:0]       cool_count;

    result_t                  pending_commands[$];
    step_row_t                directed_steps[$];

    bit hold_off_req  = 1'b0;
    bit sender_gaps   = 1'b0;
    bit receiver_gaps = 1'b0;

    int ticks_sent       = 0;
    int commands_checked = 0;
    int reg_writes       = 0;
    int mismatches       = 0;

    thermal_fan_mode_controller_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .laser_on     (laser_on),
        .module_temp  (module_temp),
        .highest_temp (highest_temp),
        .manual_power (manual_power),
        .aux_request  (aux_request),
        .aux_power    (aux_power),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive_write  (drive_write),
        .drive_on     (drive_on),
        .drive_power  (drive_power),
        .fan_state    (fan_state),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the controller hangs.
    initial
    begin
        #TIMEOUT_NS;
        $display("Timed out with %0d commands still pending.", pending_commands.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [PWR_W-1:0] clamp_power(input int unsigned p);
        return (p > PWR_FULL) ? PWR_FULL : PWR_W'(p);
    endfunction

    // Work out the command for one tick and advance the shadow state.
    function automatic result_t next_fan_command(input item_t it);
        result_t     r;
        int          temp_now;
        int          thr;
        bit          hot;
        int unsigned ramp;
        int unsigned req;
        r    = '0;
        ramp = 0;
        if (it.laser_on)
        begin
            // With the laser fan disabled the tick is ignored altogether.
            if (fan_cfg.laser_fan_enable)
            begin
                r.drive_write = 1'b1;
                r.drive_on    = 1'b1;
                r.drive_power = clamp_power(fan_cfg.laser_power);
                mode_now      = MODE_LASER;
                cool_count    = '0;
            end
        end
        else
        begin
            case (fan_cfg.temp_source)
                SRC_MODULE:  temp_now = int'($signed(it.module_temp));
                SRC_HIGHEST: temp_now = int'($signed(it.highest_temp));
                default:     temp_now = 0;
            endcase
            thr = int'($signed(fan_cfg.trip_temp));
            hot = (temp_now >= thr);
            if (hot)
            begin
                ramp = clamp_power(fan_cfg.power_init
                                   + ((unsigned'(temp_now - thr) * fan_cfg.power_step) >> 4));
            end

            if (it.manual_power != 0 || it.aux_request)
            begin
                // Accessory request: the largest of manual, accessory and ramp.
                req = it.manual_power;
                if (it.aux_request && it.aux_power > req)
                    req = it.aux_power;
                if (hot && ramp > req)
                    req = ramp;
                r.drive_write = 1'b1;
                r.drive_on    = 1'b1;
                r.drive_power = clamp_power(req);
                mode_now      = MODE_AUX;
                cool_count    = '0;
            end
            else if (hot)
            begin
                r.drive_write = 1'b1;
                r.drive_on    = 1'b1;
                r.drive_power = PWR_W'(ramp);
                mode_now      = MODE_THERMAL;
                cool_count    = '0;
            end
            else if (mode_now == MODE_AUX)
            begin
                r.drive_write = 1'b1;
                mode_now      = MODE_IDLE;
                cool_count    = '0;
            end
            else if (mode_now == MODE_LASER || mode_now == MODE_THERMAL)
            begin
                mode_now   = MODE_COOL;
                cool_count = '0;
            end
            else if (mode_now == MODE_COOL)
            begin
                cool_count = cool_count + 1'b1;
                if (cool_count > fan_cfg.cool_hold)
                begin
                    r.drive_write = 1'b1;
                    mode_now      = MODE_IDLE;
                    cool_count    = '0;
                end
            end
        end
        r.fan_state = mode_now;
        return r;
    endfunction

    function automatic item_t mk_item(input bit l, input int mt, input int ht,
                                      input int man, input bit ar, input int ap);
        item_t it;
        it.laser_on     = l;
        it.module_temp  = TEMP_W'(mt);
        it.highest_temp = TEMP_W'(ht);
        it.manual_power = PWR_W'(man);
        it.aux_request  = ar;
        it.aux_power    = PWR_W'(ap);
        return it;
    endfunction

    function automatic step_row_t known_row(input item_t it, input bit w, input bit o,
                                            input int p, input fan_mode_e s);
        step_row_t row;
        row.is_write          = 1'b0;
        row.reg_index         = '0;
        row.reg_data          = '0;
        row.tick              = it;
        row.known             = 1'b1;
        row.want.drive_write  = w;
        row.want.drive_on     = o;
        row.want.drive_power  = PWR_W'(p);
        row.want.fan_state    = s;
        return row;
    endfunction

    function automatic step_row_t open_row(input item_t it);
        step_row_t row;
        row.is_write  = 1'b0;
        row.reg_index = '0;
        row.reg_data  = '0;
        row.tick      = it;
        row.known     = 1'b0;
        row.want      = '0;
        return row;
    endfunction

    function automatic step_row_t write_row(input logic [IDX_W-1:0] idx, input int data);
        step_row_t row;
        row.is_write  = 1'b1;
        row.reg_index = idx;
        row.reg_data  = DATA_W'(data);
        row.tick      = '0;
        row.known     = 1'b0;
        row.want      = '0;
        return row;
    endfunction

    // Power picks that favor zero, full scale and the out-of-range top.
    function automatic logic [PWR_W-1:0] pick_power();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return PWR_FULL;
            2:       return '1;
            default: return PWR_W'($urandom_range(0, 1600));
        endcase
    endfunction

    // A temperature just above or below the current threshold, now and then far off.
    function automatic logic signed [TEMP_W-1:0] temp_near(input bit hot);
        int t;
        t = int'($signed(fan_cfg.trip_temp));
        if (hot)
            t += ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 32767))
                                             : int'($urandom_range(0, 160));
        else
            t -= ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 32767))
                                             : int'($urandom_range(1, 160));
        if (t > 16383)
            t = 16383;
        if (t < -16384)
            t = -16384;
        return TEMP_W'(t);
    endfunction

    // A plain tick with the selected sensor hot or cold and random noise elsewhere.
    function automatic item_t tick_item(input bit hot);
        item_t it;
        it.laser_on     = 1'b0;
        it.manual_power = '0;
        it.aux_request  = 1'b0;
        it.aux_power    = PWR_W'($urandom);
        it.module_temp  = TEMP_W'($urandom);
        it.highest_temp = TEMP_W'($urandom);
        if (fan_cfg.temp_source == SRC_MODULE)
            it.module_temp = temp_near(hot);
        else if (fan_cfg.temp_source == SRC_HIGHEST)
            it.highest_temp = temp_near(hot);
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: command %0d, %s is %0d, expected %0d",
                 $time, commands_checked, what, got, want);
        mismatches++;
    endtask

    // Offer one tick, record its expected command once the beat is taken.
    task automatic offer_tick(input item_t it, input bit known, input result_t want);
        result_t predicted;
        in_valid     <= 1'b1;
        laser_on     <= it.laser_on;
        module_temp  <= it.module_temp;
        highest_temp <= it.highest_temp;
        manual_power <= it.manual_power;
        aux_request  <= it.aux_request;
        aux_power    <= it.aux_power;
        do
            @(posedge clk);
        while (in_stall);
        predicted = next_fan_command(it);
        pending_commands.push_back(known ? want : predicted);
        ticks_sent++;
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Register writes only go out once every pending command has come back.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (pending_commands.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TRIP_TEMP:        fan_cfg.trip_temp        = data[TEMP_W-1:0];
            REG_POWER_INIT:       fan_cfg.power_init       = data[PWR_W-1:0];
            REG_POWER_STEP:       fan_cfg.power_step       = data[PWR_W-1:0];
            REG_LASER_POWER:      fan_cfg.laser_power      = data[PWR_W-1:0];
            REG_COOL_HOLD:        fan_cfg.cool_hold        = data[DELAY_W-1:0];
            REG_TEMP_SOURCE:      fan_cfg.temp_source      = data[1:0];
            REG_LASER_FAN_ENABLE: fan_cfg.laser_fan_enable = data[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // A random episode: heat, laser or accessory ticks and a cold tail, or noise ticks.
    task automatic run_episode();
        item_t       it;
        logic [63:0] noise;
        int          kind;
        int          lead;
        int          tail;
        kind = $urandom_range(0, 9);
        lead = $urandom_range(1, 4);
        if (kind >= 8)
        begin
            repeat (lead)
            begin
                noise = {$urandom, $urandom};
                offer_tick(noise[$bits(item_t)-1:0], 1'b0, '0);
            end
            return;
        end
        repeat (lead)
        begin
            it = tick_item(kind < 3 || $urandom_range(0, 1) == 0);
            if (kind == 3 || kind == 4)
                it.laser_on = 1'b1;
            if (kind >= 5)
            begin
                it.manual_power = ($urandom_range(0, 1) == 0) ? pick_power() : '0;
                it.aux_request  = 1'($urandom_range(0, 1));
                it.aux_power    = pick_power();
                if (kind != 7 && it.manual_power == 0)
                    it.aux_request = 1'b1;
            end
            offer_tick(it, 1'b0, '0);
        end
        // Drop below the threshold and, where the delay is short, ride out the cooldown.
        tail = (fan_cfg.cool_hold <= 8) ? int'(fan_cfg.cool_hold) + $urandom_range(1, 3)
                                        : $urandom_range(1, 6);
        repeat (tail)
        begin
            it = tick_item(1'b0);
            it.laser_on = ($urandom_range(0, 7) == 0);
            offer_tick(it, 1'b0, '0);
        end
    endtask

    // Output side: random stall bursts, plus one long hold-off on request.
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end
            else if (receiver_gaps && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted command beat with the oldest expectation.
    always @(posedge clk)
    begin : check_commands
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_commands.size() == 0)
            begin
                report_mismatch("fan_state with nothing pending", fan_state, -1);
            end
            else
            begin
                want = pending_commands.pop_front();
                if (drive_write !== want.drive_write)
                    report_mismatch("drive_write", drive_write, want.drive_write);
                if (drive_on !== want.drive_on)
                    report_mismatch("drive_on", drive_on, want.drive_on);
                if (drive_power !== want.drive_power)
                    report_mismatch("drive_power", drive_power, want.drive_power);
                if (fan_state !== want.fan_state)
                    report_mismatch("fan_state", fan_state, want.fan_state);
            end
            commands_checked++;
        end
    end

    initial
    begin : stimulus
        int          phase_start;
        int          thr;
        logic [1:0]  src;
        logic [10:0] step;
        step_row_t   row;

        fan_cfg    = '{trip_temp: 15'sd560, power_init: 11'd800, power_step: 11'd160,
                       laser_power: 11'd1280, cool_hold: 16'd180,
                       temp_source: SRC_ZERO, laser_fan_enable: 1'b0};
        mode_now   = MODE_IDLE;
        cool_count = '0;

        // Reset settings: sensor ignored, laser fan off, accessory paths and saturation.
        directed_steps.push_back(known_row(mk_item(0, 0, 0, 0, 0, 0), 0, 0, 0, MODE_IDLE));
        directed_steps.push_back(known_row(mk_item(1, 0, 0, 0, 0, 0), 0, 0, 0, MODE_IDLE));
        directed_steps.push_back(known_row(mk_item(0, 0, 0, 2047, 0, 0), 1, 1, 1600, MODE_AUX));
        directed_steps.push_back(known_row(mk_item(0, 0, 0, 0, 0, 0), 1, 0, 0, MODE_IDLE));
        directed_steps.push_back(known_row(mk_item(0, 0, 0, 0, 1, 1600), 1, 1, 1600, MODE_AUX));
        directed_steps.push_back(known_row(mk_item(1, 0, 0, 0, 0, 0), 0, 0, 0, MODE_AUX));
        directed_steps.push_back(known_row(mk_item(0, 0, 0, 0, 1, 0), 1, 1, 0, MODE_AUX));
        directed_steps.push_back(known_row(mk_item(0, 0, 0, 0, 0, 0), 1, 0, 0, MODE_IDLE));

        // Module sensor, laser fan on with an oversized power, a cooldown hold of 1.
        directed_steps.push_back(write_row(REG_TEMP_SOURCE, SRC_MODULE));
        directed_steps.push_back(write_row(REG_LASER_FAN_ENABLE, 1));
        directed_steps.push_back(write_row(REG_COOL_HOLD, 1));
        directed_steps.push_back(write_row(REG_LASER_POWER, 2047));
        directed_steps.push_back(write_row(REG_UNUSED, 16'hFFFF));
        directed_steps.push_back(known_row(mk_item(1, 0, 0, 0, 0, 0), 1, 1, 1600, MODE_LASER));
        directed_steps.push_back(known_row(mk_item(0, 0, 0, 0, 0, 0), 0, 0, 0, MODE_COOL));
        directed_steps.push_back(known_row(mk_item(0, 0, 0, 0, 0, 0), 0, 0, 0, MODE_COOL));
        directed_steps.push_back(known_row(mk_item(0, 0, 0, 0, 0, 0), 1, 0, 0, MODE_IDLE));
        directed_steps.push_back(known_row(mk_item(0, 560, 0, 0, 0, 0), 1, 1, 800, MODE_THERMAL));
        directed_steps.push_back(known_row(mk_item(0, 16383, -16384, 0, 0, 0),
                                           1, 1, 1600, MODE_THERMAL));
        directed_steps.push_back(known_row(mk_item(0, -16384, 16383, 0, 0, 0),
                                           0, 0, 0, MODE_COOL));
        directed_steps.push_back(known_row(mk_item(1, 16383, 0, 0, 0, 0), 1, 1, 1600, MODE_LASER));
        directed_steps.push_back(open_row(mk_item(0, 577, 0, 500, 1, 900)));
        directed_steps.push_back(open_row(mk_item(0, 600, 16383, 0, 1, 2047)));

        // The reserved source code reads as zero.
        directed_steps.push_back(write_row(REG_TEMP_SOURCE, SRC_RESERVED));
        directed_steps.push_back(known_row(mk_item(0, 16383, 16383, 0, 0, 0), 1, 0, 0, MODE_IDLE));

        // Highest sensor against both threshold extremes, with a steep ramp from zero.
        directed_steps.push_back(write_row(REG_TEMP_SOURCE, SRC_HIGHEST));
        directed_steps.push_back(write_row(REG_TRIP_TEMP, -16384));
        directed_steps.push_back(write_row(REG_POWER_STEP, 2047));
        directed_steps.push_back(write_row(REG_POWER_INIT, 0));
        directed_steps.push_back(known_row(mk_item(0, 0, -16384, 0, 0, 0),
                                           1, 1, 0, MODE_THERMAL));
        directed_steps.push_back(known_row(mk_item(0, 0, 16383, 0, 0, 0),
                                           1, 1, 1600, MODE_THERMAL));
        directed_steps.push_back(write_row(REG_TRIP_TEMP, 16383));
        directed_steps.push_back(known_row(mk_item(0, 0, 16383, 0, 0, 0), 1, 1, 0, MODE_THERMAL));
        directed_steps.push_back(known_row(mk_item(0, 16383, 16382, 0, 0, 0), 0, 0, 0, MODE_COOL));
        directed_steps.push_back(known_row(mk_item(0, 0, 0, 0, 0, 0), 0, 0, 0, MODE_COOL));
        directed_steps.push_back(known_row(mk_item(0, 0, 0, 0, 0, 0), 1, 0, 0, MODE_IDLE));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;

        foreach (directed_steps[i])
        begin
            row = directed_steps[i];
            if (row.is_write)
                write_reg(row.reg_index, row.reg_data);
            else
                offer_tick(row.tick, row.known, row.want);
        end

        // Long output hold-off with back-to-back ticks, so the input side backs up.
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
        repeat (24) offer_tick(tick_item($urandom_range(0, 1) == 1), 1'b0, '0);
        sender_gaps = 1'b1;

        // Random phases, each under its own settings; the last one runs without idling.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == PHASES - 1)
            begin
                sender_gaps   = 1'b0;
                receiver_gaps = 1'b0;
            end
            case (phase)
                1:       thr = -16384;
                2:       thr = 16383;
                default: thr = int'($urandom_range(0, 1200)) - 200;
            endcase
            case (phase)
                0:       src = SRC_ZERO;
                2, 5:    src = SRC_HIGHEST;
                4:       src = SRC_RESERVED;
                default: src = SRC_MODULE;
            endcase
            case ($urandom_range(0, 3))
                0:       step = '0;
                1:       step = '1;
                default: step = 11'($urandom_range(1, 320));
            endcase
            write_reg(REG_TRIP_TEMP, DATA_W'(thr));
            write_reg(REG_POWER_INIT, DATA_W'(pick_power()));
            write_reg(REG_POWER_STEP, DATA_W'(step));
            write_reg(REG_LASER_POWER, DATA_W'(pick_power()));
            write_reg(REG_COOL_HOLD, (phase == 3) ? 16'hFFFF
                                                  : DATA_W'($urandom_range(0, 6)));
            write_reg(REG_TEMP_SOURCE, DATA_W'(src));
            write_reg(REG_LASER_FAN_ENABLE, DATA_W'(phase != 2));
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS)
                run_episode();
        end

        // Let the last commands come out, then wait for strays.
        in_valid <= 1'b0;
        while (pending_commands.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d ticks: directed corners, an output hold-off and %0d random",
                 ticks_sent, PHASES);
        $display("settings phases; %0d register writes, %0d commands checked, %0d mismatches.",
                 reg_writes, commands_checked, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
